/* rtl/core/elic_pkg.sv */
package elic_pkg;

    // Operation codes carried by an input transfer
    typedef enum logic [1:0] {
        OP_LINE  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Register map
    typedef enum logic [2:0] {
        REG_EVENTS_HI = 3'd0,
        REG_MASK_HI   = 3'd1,
        REG_LEVELS_HI = 3'd2,
        REG_CLEAR_HI  = 3'd3,
        REG_EVENTS_LO = 3'd4,
        REG_MASK_LO   = 3'd5,
        REG_LEVELS_LO = 3'd6,
        REG_CLEAR_LO  = 3'd7
    } reg_idx_t;

    localparam int unsigned NUM_LINES  = 64;
    localparam int unsigned LINE_W     = 6;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned MODE_BIT   = 31;
    localparam logic [DATA_W-1:0] LOW31_MASK = 32'h7FFF_FFFF;
    localparam logic [NUM_LINES-1:0] HI_KEEP = 64'h7FFF_FFFF_0000_0000;

    // One captured command
    typedef struct packed {
        op_t               op;
        reg_idx_t          idx;
        logic [DATA_W-1:0] data;
        logic [LINE_W-1:0] line;
        logic              state;
    } item_t;

    // Input stage to core
    typedef struct packed {
        logic  valid;
        item_t item;
    } stage_t;

endpackage

/* rtl/core/edge_level_interrupt_controller.sv */
// 64-line interrupt controller with edge and level event capture.
//
// Command channel: drive operation, reg_index, write_data, line_number and
// line_state with start high; the transfer happens at a clock edge where
// start is high and busy is low. busy stays low, so a command may be
// issued in every cycle.
// Result channel: done is high for exactly one cycle per command, once the
// command has passed the input register and then the update logic into
// the result register. read_data and cpu_interrupt are valid while done is
// high; cpu_interrupt is the latch state after the command. The receiver
// must take each result in that cycle; it cannot stall the block.
// Throughput is one command per cycle: each command updates the event,
// mask and level vectors in a single pass, and the next command sees the
// updated vectors.
// Reset (rst_n low) clears the event, mask and level vectors, the CPU
// latch and any command in flight.
module edge_level_interrupt_controller
    import elic_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        operation,
    input  logic [2:0]        reg_index,
    input  logic [DATA_W-1:0] write_data,
    input  logic [LINE_W-1:0] line_number,
    input  logic              line_state,
    output logic              done,
    output logic [DATA_W-1:0] read_data,
    output logic              cpu_interrupt
);

    logic   take;
    item_t  item;
    stage_t stage;

    assign busy = 1'b0;
    assign take = start && !busy;

    // Pack the command fields
    assign item.op    = op_t'(operation);
    assign item.idx   = reg_idx_t'(reg_index);
    assign item.data  = write_data;
    assign item.line  = line_number;
    assign item.state = line_state;

    elic_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (item),
        .stage (stage)
    );

    elic_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .stage         (stage),
        .done          (done),
        .read_data     (read_data),
        .cpu_interrupt (cpu_interrupt)
    );

    // Every transfer yields a result
    assert property (@(posedge clk) disable iff (!rst_n)
        take |=> ##1 done)
        else $error("result missing after command transfer");

    // No result without an earlier transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(take, 2))
        else $error("result without command transfer");

    // Only reads return nonzero data
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && read_data != '0) |-> ($past(operation, 2) == OP_READ))
        else $error("nonzero read data for a non-read command");

    // The latch only rises on a line change or a write
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && cpu_interrupt && !$past(cpu_interrupt)) |->
            ($past(operation, 2) == OP_LINE || $past(operation, 2) == OP_WRITE))
        else $error("interrupt latch set by a read or no-op");

endmodule

/* rtl/core/elic_in_stage.sv */
module elic_in_stage
    import elic_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   take,
    input  item_t  item,
    output stage_t stage
);

    logic  valid_reg;
    item_t item_reg;

    // Track which cycles hold a captured command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= take;
        end
    end

    // Capture payload on each transfer
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

/* rtl/core/elic_core.sv */
module elic_core
    import elic_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  stage_t            stage,
    output logic              done,
    output logic [DATA_W-1:0] read_data,
    output logic              cpu_interrupt
);

    logic [NUM_LINES-1:0] event_reg, event_next;
    logic [NUM_LINES-1:0] mask_reg,  mask_next;
    logic [NUM_LINES-1:0] level_reg, level_next;
    logic                 latch_reg, latch_next;
    logic                 done_reg;
    logic [DATA_W-1:0]    rd_reg,    rd_next;
    logic                 try_raise;
    logic                 try_release;
    logic                 pending;
    logic [DATA_W-1:0]    data_low31;

    assign data_low31 = stage.item.data & LOW31_MASK;
    assign pending    = |(event_next & mask_next);

    // Compute the new vectors and the read value for the captured command
    always_comb
    begin
        event_next  = event_reg;
        mask_next   = mask_reg;
        level_next  = level_reg;
        rd_next     = '0;
        try_raise   = 1'b0;
        try_release = 1'b0;
        if (stage.valid)
        begin
            case (stage.item.op)
                OP_LINE:
                begin
                    if (mask_reg[MODE_BIT] ||
                        (stage.item.state && !level_reg[stage.item.line]))
                    begin
                        event_next[stage.item.line] = 1'b1;
                    end
                    else
                    begin
                        event_next[stage.item.line] = 1'b0;
                    end
                    level_next[stage.item.line] = stage.item.state;
                    try_raise = 1'b1;
                end
                OP_READ:
                begin
                    case (stage.item.idx)
                        REG_EVENTS_HI: rd_next = event_reg[NUM_LINES-1:DATA_W];
                        REG_MASK_HI:   rd_next = mask_reg[NUM_LINES-1:DATA_W];
                        REG_LEVELS_HI: rd_next = level_reg[NUM_LINES-1:DATA_W];
                        REG_EVENTS_LO: rd_next = event_reg[DATA_W-1:0];
                        REG_MASK_LO:   rd_next = mask_reg[DATA_W-1:0];
                        REG_LEVELS_LO: rd_next = level_reg[DATA_W-1:0];
                        default:       rd_next = '0;
                    endcase
                end
                OP_WRITE:
                begin
                    case (stage.item.idx)
                        REG_MASK_HI:
                        begin
                            mask_next[NUM_LINES-1:DATA_W] =
                                mask_reg[NUM_LINES-1:DATA_W] | data_low31;
                            try_raise = 1'b1;
                        end
                        REG_CLEAR_HI:
                        begin
                            event_next[NUM_LINES-1:DATA_W] =
                                event_reg[NUM_LINES-1:DATA_W] & ~data_low31;
                            try_release = 1'b1;
                        end
                        REG_MASK_LO:
                        begin
                            // Replace low half, mirror the mode bit into the top bit
                            mask_next = (mask_reg & HI_KEEP) | {32'd0, stage.item.data};
                            mask_next[NUM_LINES-1] = stage.item.data[MODE_BIT];
                            try_raise = 1'b1;
                        end
                        REG_CLEAR_LO:
                        begin
                            // In mode, data bit 31 clears every event
                            if (mask_reg[MODE_BIT] && stage.item.data[MODE_BIT])
                            begin
                                event_next = '0;
                            end
                            else
                            begin
                                event_next[DATA_W-1:0] = event_reg[DATA_W-1:0] & ~data_low31;
                            end
                            try_release = 1'b1;
                        end
                        default:
                        begin
                            event_next = event_reg;
                        end
                    endcase
                end
                default:
                begin
                    rd_next = '0;
                end
            endcase
        end
    end

    // Set or release the CPU latch from the updated product
    always_comb
    begin
        latch_next = latch_reg;
        if (try_raise && pending)
        begin
            latch_next = 1'b1;
        end
        else if (try_release && !pending)
        begin
            latch_next = 1'b0;
        end
    end

    // Hold state vectors and the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            event_reg <= '0;
            mask_reg  <= '0;
            level_reg <= '0;
            latch_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            event_reg <= event_next;
            mask_reg  <= mask_next;
            level_reg <= level_next;
            latch_reg <= latch_next;
            done_reg  <= stage.valid;
        end
    end

    // Register the read value with the strobe
    always_ff @(posedge clk)
    begin
        if (stage.valid)
        begin
            rd_reg <= rd_next;
        end
    end

    assign done          = done_reg;
    assign read_data     = rd_reg;
    assign cpu_interrupt = latch_reg;

endmodule
